// File: rtl/fcd_pkg.sv
// ----------------------------------------------------------------------------
// fcd_pkg
// Constants, codes and the CRC-16 byte update shared by the frame deframer.
// ----------------------------------------------------------------------------
package fcd_pkg;

  localparam int HANDSHAKE_BYTES = 71;
  localparam int PAYLOAD_BYTES   = 1024;
  localparam int SUB_PACKETS     = 16;

  localparam int POS_W = 11;
  localparam int SUB_W = 4;

  localparam logic [POS_W-1:0] SHAKE_LEN     = POS_W'(HANDSHAKE_BYTES);
  localparam logic [POS_W-1:0] SUB_LEN       = POS_W'(PAYLOAD_BYTES + 9);
  localparam logic [POS_W-1:0] PAYLOAD_FIRST = POS_W'(7);

  localparam logic [7:0]  LEAD_HANDSHAKE = 8'h3A;
  localparam logic [7:0]  LEAD_DATA      = 8'h3B;
  localparam logic [15:0] CRC_POLY       = 16'h1021;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [1:0] ST_SHAKE_OK  = 2'd0;
  localparam logic [1:0] ST_SHAKE_BAD = 2'd1;
  localparam logic [1:0] ST_DATA_OK   = 2'd2;
  localparam logic [1:0] ST_DATA_BAD  = 2'd3;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/frame_crc_deframer.sv
// ----------------------------------------------------------------------------
// frame_crc_deframer
// Byte-serial frame checker with CRC-16/XMODEM over handshake and data frames.
// ----------------------------------------------------------------------------
// Input channel: one received byte per transaction on data_byte_i with
// in_valid_i / in_ready_o. While hunting, 0x3A opens a handshake frame and
// 0x3B opens a data frame of sub-packets; other bytes are dropped.
// Output channel: out_valid_o / out_ready_i carry either a payload byte
// (out_kind_o 0, with sub_index_o) or one end-of-frame status (out_kind_o 1,
// frame_status_o). The consumer discards a frame's payload on a bad status.
// A result is registered and appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle while results are taken; the CRC byte update
// and the frame counters are combinational logic ahead of the result register.
// The result register frees as it is taken, so a new byte is accepted in the
// same cycle that a waiting result leaves.
// When the receiver stalls, the pending result holds and in_ready_o drops
// until it is taken.
// Reset: hunting state, counters and CRC cleared, no result pending.
// ----------------------------------------------------------------------------
module frame_crc_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [3:0] sub_index_o,
  output logic [1:0] frame_status_o
);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SHAKE = 2'd1,
    PH_DATA  = 2'd2
  } phase_e;

  localparam int PW = fcd_pkg::POS_W;
  localparam int SW = fcd_pkg::SUB_W;

  phase_e                 phase_q, phase_d;
  logic [PW-1:0]          pos_q, pos_d;
  logic [SW-1:0]          sub_q, sub_d;
  logic [15:0]            crc_q, crc_d;
  logic [7:0]             crc_low_q, crc_low_d;
  logic                   err_q, err_d;

  logic                   out_valid_q;
  logic                   res_valid;
  logic                   res_kind;
  logic [7:0]             res_byte;
  logic [SW-1:0]          res_sub;
  logic [1:0]             res_status;
  logic                   out_kind_q;
  logic [7:0]             out_byte_q;
  logic [SW-1:0]          out_sub_q;
  logic [1:0]             out_status_q;

  logic                   accept;
  logic [PW-1:0]          len;
  logic [PW:0]            pos_ext;
  logic [PW:0]            len_ext;
  logic                   bad;
  logic                   last_sub;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign len      = (phase_q == PH_SHAKE) ? fcd_pkg::SHAKE_LEN : fcd_pkg::SUB_LEN;
  assign pos_ext  = {1'b0, pos_q};
  assign len_ext  = {1'b0, len};
  assign bad      = {data_byte_i, crc_low_q} != crc_q;
  assign last_sub = ({1'b0, sub_q} + (SW+1)'(1)) >= (SW+1)'(fcd_pkg::SUB_PACKETS);

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    sub_d      = sub_q;
    crc_d      = crc_q;
    crc_low_d  = crc_low_q;
    err_d      = err_q;
    res_valid  = 1'b0;
    res_kind   = fcd_pkg::KIND_PAYLOAD;
    res_byte   = '0;
    res_sub    = '0;
    res_status = fcd_pkg::ST_SHAKE_OK;
    case (phase_q)
      PH_SHAKE, PH_DATA: begin
        if (pos_q != '0 && (pos_ext + (PW+1)'(3)) <= len_ext) begin
          crc_d = fcd_pkg::crc_update(crc_q, data_byte_i);
          pos_d = pos_q + PW'(1);
          if (phase_q == PH_DATA && pos_q >= fcd_pkg::PAYLOAD_FIRST) begin
            res_valid = 1'b1;
            res_byte  = data_byte_i;
            res_sub   = sub_q;
          end
        end else if ((pos_ext + (PW+1)'(2)) == len_ext) begin
          crc_low_d = data_byte_i;
          pos_d     = pos_q + PW'(1);
        end else if ((pos_ext + (PW+1)'(1)) == len_ext) begin
          if (phase_q == PH_SHAKE || last_sub) begin
            res_valid = 1'b1;
            res_kind  = fcd_pkg::KIND_STATUS;
            if (phase_q == PH_SHAKE) begin
              res_status = bad ? fcd_pkg::ST_SHAKE_BAD : fcd_pkg::ST_SHAKE_OK;
            end else begin
              res_status = (err_q || bad) ? fcd_pkg::ST_DATA_BAD : fcd_pkg::ST_DATA_OK;
            end
            phase_d   = PH_HUNT;
            pos_d     = '0;
            sub_d     = '0;
            crc_d     = '0;
            crc_low_d = '0;
            err_d     = 1'b0;
          end else begin
            err_d     = err_q || bad;
            sub_d     = sub_q + SW'(1);
            pos_d     = '0;
            crc_d     = '0;
            crc_low_d = '0;
          end
        end else if (pos_q == '0) begin
          pos_d = PW'(1);
        end else begin
          phase_d   = PH_HUNT;
          pos_d     = '0;
          sub_d     = '0;
          crc_d     = '0;
          crc_low_d = '0;
          err_d     = 1'b0;
        end
      end
      default: begin
        phase_d = PH_HUNT;
        if (data_byte_i == fcd_pkg::LEAD_HANDSHAKE || data_byte_i == fcd_pkg::LEAD_DATA) begin
          phase_d   = (data_byte_i == fcd_pkg::LEAD_HANDSHAKE) ? PH_SHAKE : PH_DATA;
          pos_d     = PW'(1);
          sub_d     = '0;
          crc_d     = '0;
          crc_low_d = '0;
          err_d     = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      pos_q        <= '0;
      sub_q        <= '0;
      crc_q        <= '0;
      crc_low_q    <= '0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= fcd_pkg::KIND_PAYLOAD;
      out_byte_q   <= '0;
      out_sub_q    <= '0;
      out_status_q <= fcd_pkg::ST_SHAKE_OK;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        sub_q       <= sub_d;
        crc_q       <= crc_d;
        crc_low_q   <= crc_low_d;
        err_q       <= err_d;
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept && res_valid) begin
        out_kind_q   <= res_kind;
        out_byte_q   <= res_byte;
        out_sub_q    <= res_sub;
        out_status_q <= res_status;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign payload_byte_o = out_byte_q;
  assign sub_index_o    = out_sub_q;
  assign frame_status_o = out_status_q;

endmodule
